// ===== src/mtd_pkg.sv =====
package mtd_pkg;

  localparam int unsigned MaxSymbols = 5;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned OutDepth   = 4;

  localparam logic [31:0] DotMinReset  = 32'd60000;
  localparam logic [31:0] DotMaxReset  = 32'd400000;
  localparam logic [31:0] DashMaxReset = 32'd800000;
  localparam logic [31:0] GapReset     = 32'd800000;

  localparam logic [6:0] CharDot   = 7'h2E;
  localparam logic [6:0] CharDash  = 7'h2D;
  localparam logic [6:0] CharSpace = 7'h20;
  localparam logic [6:0] CharA     = 7'h41;

  typedef enum logic [1:0] {
    KindDot    = 2'd0,
    KindDash   = 2'd1,
    KindLetter = 2'd2,
    KindSpace  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CfgDotMin  = 2'd0,
    CfgDotMax  = 2'd1,
    CfgDashMax = 2'd2,
    CfgGap     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] dot_min;
    logic [31:0] dot_max;
    logic [31:0] dash_max;
    logic [31:0] gap;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] char_code;
    logic       last;
  } result_t;

  // num gives how many of the two results are pushed this cycle (0, 1 or 2).
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  // Number of symbols in each letter A..Z.
  function automatic logic [2:0] letter_len(input logic [4:0] idx);
    logic [2:0] r;
    unique case (idx)
      5'd0:  r = 3'd2;  5'd1:  r = 3'd4;  5'd2:  r = 3'd4;  5'd3:  r = 3'd3;
      5'd4:  r = 3'd1;  5'd5:  r = 3'd4;  5'd6:  r = 3'd3;  5'd7:  r = 3'd4;
      5'd8:  r = 3'd2;  5'd9:  r = 3'd4;  5'd10: r = 3'd3;  5'd11: r = 3'd4;
      5'd12: r = 3'd2;  5'd13: r = 3'd2;  5'd14: r = 3'd3;  5'd15: r = 3'd4;
      5'd16: r = 3'd4;  5'd17: r = 3'd3;  5'd18: r = 3'd3;  5'd19: r = 3'd1;
      5'd20: r = 3'd3;  5'd21: r = 3'd4;  5'd22: r = 3'd3;  5'd23: r = 3'd4;
      5'd24: r = 3'd4;  5'd25: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Symbol pattern of each letter, bit i = symbol i, set for a dash.
  function automatic logic [3:0] letter_pat(input logic [4:0] idx);
    logic [3:0] r;
    unique case (idx)
      5'd0:  r = 4'd2;  5'd1:  r = 4'd1;  5'd2:  r = 4'd5;  5'd3:  r = 4'd1;
      5'd4:  r = 4'd0;  5'd5:  r = 4'd4;  5'd6:  r = 4'd3;  5'd7:  r = 4'd0;
      5'd8:  r = 4'd0;  5'd9:  r = 4'd14; 5'd10: r = 4'd5;  5'd11: r = 4'd2;
      5'd12: r = 4'd3;  5'd13: r = 4'd1;  5'd14: r = 4'd7;  5'd15: r = 4'd6;
      5'd16: r = 4'd11; 5'd17: r = 4'd2;  5'd18: r = 4'd0;  5'd19: r = 4'd1;
      5'd20: r = 4'd4;  5'd21: r = 4'd8;  5'd22: r = 4'd6;  5'd23: r = 4'd9;
      5'd24: r = 4'd13; 5'd25: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mtd_core.sv =====
module mtd_core #(
  parameter int unsigned MAX_SYMBOLS = mtd_pkg::MaxSymbols
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            operation_i,
  input  logic [31:0]     timestamp_i,
  input  mtd_pkg::cfg_t   cfg_i,
  output mtd_pkg::push_t  push_o
);

  localparam int unsigned CntW = $clog2(MAX_SYMBOLS + 1);

  logic [31:0]            last_edge_q, last_edge_d;
  logic                   expect_open_q, expect_open_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [MAX_SYMBOLS-1:0] bits_q, bits_d;
  logic                   overflow_q, overflow_d;

  logic [31:0] delta;
  logic        is_dot, is_dash, gap_hit;
  logic        found;
  logic [4:0]  letter_idx;

  assign delta   = timestamp_i - last_edge_q;
  assign is_dot  = (delta >= cfg_i.dot_min) && (delta <= cfg_i.dot_max);
  assign is_dash = !is_dot && (delta > cfg_i.dot_max) && (delta <= cfg_i.dash_max);
  assign gap_hit = delta > cfg_i.gap;

  // Letter lookup; an overflowed or empty sequence never matches.
  always_comb begin
    found      = 1'b0;
    letter_idx = '0;
    for (int i = 0; i < mtd_pkg::NumLetters; i++) begin
      if (!found && !overflow_q && (count_q != '0)
          && (count_q == CntW'(mtd_pkg::letter_len(5'(i))))
          && (bits_q == MAX_SYMBOLS'(mtd_pkg::letter_pat(5'(i))))) begin
        found      = 1'b1;
        letter_idx = 5'(i);
      end
    end
  end

  always_comb begin
    last_edge_d   = last_edge_q;
    expect_open_d = expect_open_q;
    count_d       = count_q;
    bits_d        = bits_q;
    overflow_d    = overflow_q;
    push_o        = '0;
    push_o.first  = '{kind: mtd_pkg::KindSpace, char_code: mtd_pkg::CharSpace, last: 1'b1};
    push_o.second = '{kind: mtd_pkg::KindSpace, char_code: mtd_pkg::CharSpace, last: 1'b1};
    if (accept_i) begin
      if (!operation_i) begin
        last_edge_d   = timestamp_i;
        expect_open_d = !expect_open_q;
        if (!expect_open_q && (is_dot || is_dash)) begin
          if (count_q < CntW'(MAX_SYMBOLS)) begin
            if (is_dash) begin
              bits_d = bits_q | (MAX_SYMBOLS'(1) << count_q);
            end
            count_d = count_q + CntW'(1);
          end else begin
            overflow_d = 1'b1;
          end
          push_o.num = 2'd1;
          if (is_dot) begin
            push_o.first = '{kind: mtd_pkg::KindDot, char_code: mtd_pkg::CharDot, last: 1'b1};
          end else begin
            push_o.first = '{kind: mtd_pkg::KindDash, char_code: mtd_pkg::CharDash, last: 1'b1};
          end
        end
      end else if (gap_hit) begin
        last_edge_d = timestamp_i;
        count_d     = '0;
        bits_d      = '0;
        overflow_d  = 1'b0;
        if (found) begin
          push_o.num   = 2'd2;
          push_o.first = '{kind: mtd_pkg::KindLetter,
                           char_code: mtd_pkg::CharA + 7'(letter_idx), last: 1'b0};
        end else begin
          push_o.num = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q   <= '0;
      expect_open_q <= 1'b1;
      count_q       <= '0;
      bits_q        <= '0;
      overflow_q    <= 1'b0;
    end else begin
      last_edge_q   <= last_edge_d;
      expect_open_q <= expect_open_d;
      count_q       <= count_d;
      bits_q        <= bits_d;
      overflow_q    <= overflow_d;
    end
  end

endmodule

// ===== src/mtd_outq.sv =====
module mtd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtd_pkg::push_t    push_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mtd_pkg::result_t  result_o,
  output logic [2:0]        count_o
);

  localparam int unsigned PtrW = $clog2(mtd_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(mtd_pkg::OutDepth + 1);

  mtd_pkg::result_t mem_q [mtd_pkg::OutDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  assign valid_o  = count_q != '0;
  assign result_o = mem_q[rd_ptr_q];
  assign pop      = valid_o && ready_i;
  // Room for the worst case of two results from the next item.
  assign space_o  = count_q <= CntW'(mtd_pkg::OutDepth - 2);
  assign count_o  = 3'(count_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/morse_timing_decoder.sv =====
// An accepted item's results are registered in the result queue. Throughput:
// one item per cycle while the queue has room; a poll that ends a letter yields
// two results; the four-entry queue drains one result per cycle with out_ready_i.
// Input ready is high while the queue holds two or fewer results.
// Reset (rst_ni low, asynchronous) restores the default thresholds, empties the
// sequence and the result queue, and expects an opening edge next.
module morse_timing_decoder #(
  parameter int unsigned MAX_SYMBOLS = mtd_pkg::MaxSymbols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [6:0]  char_code_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  mtd_pkg::cfg_t    cfg_q, cfg_d;
  mtd_pkg::push_t   push;
  mtd_pkg::result_t result;
  logic             accept;
  logic             space;
  logic [2:0]       q_count;

  // The threshold registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mtd_pkg::cfg_idx_e'(cfg_index_i))
        mtd_pkg::CfgDotMin:  cfg_d.dot_min  = cfg_data_i;
        mtd_pkg::CfgDotMax:  cfg_d.dot_max  = cfg_data_i;
        mtd_pkg::CfgDashMax: cfg_d.dash_max = cfg_data_i;
        mtd_pkg::CfgGap:     cfg_d.gap      = cfg_data_i;
        default:             cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_min  <= mtd_pkg::DotMinReset;
      cfg_q.dot_max  <= mtd_pkg::DotMaxReset;
      cfg_q.dash_max <= mtd_pkg::DashMaxReset;
      cfg_q.gap      <= mtd_pkg::GapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // An item is taken whenever the queue can absorb its worst case of two results,
  // so the decoder stalls only while three or more results are still waiting.
  assign in_ready_o = space;
  assign accept     = in_valid_i && in_ready_o;

  // The decoder classifies the interval, updates the symbol sequence and
  // looks up the letter, all in the cycle the item is accepted.
  mtd_core #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(operation_i),
    .timestamp_i(timestamp_i),
    .cfg_i      (cfg_q),
    .push_o     (push)
  );

  // The result queue separates the decoder from the output handshake.
  mtd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .result_o(result),
    .count_o (q_count)
  );

  assign kind_o      = result.kind;
  assign char_code_o = result.char_code;
  assign last_o      = result.last;

`ifndef SYNTHESIS
  // The queue never holds more results than it has entries.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= 3'(mtd_pkg::OutDepth))
    else $error("result queue overflow");

  // A letter is always followed by a space from the same item.
  a_letter_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == mtd_pkg::KindLetter) |-> !last_o)
    else $error("letter marked as final result");

  // A space closes its item and carries the space character.
  a_space_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == mtd_pkg::KindSpace) |-> last_o
      && (char_code_o == mtd_pkg::CharSpace))
    else $error("space result malformed");

  // Nothing is accepted while the queue could not take two more results.
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count > 3'(mtd_pkg::OutDepth - 2)) |-> !accept)
    else $error("item accepted without queue room");
`endif

endmodule

// ===== verif/morse_timing_decoder_tb.sv =====
`timescale 1ns / 1ps

// Checks the Morse timing decoder end to end. Key edges and idle polls are queued by the
// stimulus process, and a driver offers them to the block. A local decoder, kept in step
// with every accepted item, predicts the symbols, letters and spaces that must come out.
// A result checker compares each result with the oldest prediction.
module morse_timing_decoder_tb;

  localparam logic OpEdge = 1'b0;
  localparam logic OpPoll = 1'b1;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic        op;
    logic [31:0] ts;
  } key_item_t;

  typedef struct packed {
    mtd_pkg::kind_e kind;
    logic [6:0]     code;
    logic           last;
  } decoded_t;

  // Standard Morse patterns for A to Z, dots and dashes in keying order.
  string morse_code [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                             ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-",
                             ".-.", "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 op = OpEdge;
  logic [31:0]          ts = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           kind;
  logic [6:0]           char_code;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  mtd_pkg::cfg_idx_e    cfg_index = mtd_pkg::CfgDotMin;
  logic [31:0]          cfg_data = '0;

  morse_timing_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (op),
    .timestamp_i (ts),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (kind),
    .char_code_o (char_code),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Items waiting to be offered, and results the local decoder expects, oldest first.
  key_item_t   pending_keys [$];
  decoded_t    expected_symbols [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  // Threshold registers as the block should hold them.
  logic [31:0] thresholds [4];

  // Local decoder state: time of the last edge or accepted poll, whether the next edge
  // opens the key, the dots and dashes stored so far, and whether one was dropped.
  logic [31:0] key_last_time = '0;
  logic        key_opening = 1'b1;
  string       key_sequence = "";
  logic        key_overflow = 1'b0;

  // Stimulus side view of the same timeline, used only to shape well-formed letters.
  logic [31:0] gen_time = '0;
  int unsigned items_queued = 0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_symbol(mtd_pkg::kind_e k, logic [6:0] code, logic is_last);
    decoded_t r;
    r.kind = k;
    r.code = code;
    r.last = is_last;
    expected_symbols.push_back(r);
  endtask

  // Advances the local decoder by one accepted item and queues the results it causes.
  task automatic decode_key(logic item_op, logic [31:0] stamp);
    logic [31:0] span;
    logic        was_opening;
    logic        got_symbol;
    logic        is_dash;
    int          letter;
    span = stamp - key_last_time;
    got_symbol = 1'b0;
    is_dash = 1'b0;
    letter = -1;
    if (item_op == OpEdge) begin
      was_opening = key_opening;
      key_opening = !key_opening;
      key_last_time = stamp;
      // A closing edge is classed by the time the key was held down. The dot test
      // comes first, so overlapping ranges favor the dot.
      if (!was_opening) begin
        if (span >= thresholds[mtd_pkg::CfgDotMin]
            && span <= thresholds[mtd_pkg::CfgDotMax]) begin
          got_symbol = 1'b1;
        end else if (span > thresholds[mtd_pkg::CfgDotMax]
                     && span <= thresholds[mtd_pkg::CfgDashMax]) begin
          got_symbol = 1'b1;
          is_dash = 1'b1;
        end
      end
      if (got_symbol) begin
        // Once the sequence is full, symbols are still reported but spoil the letter.
        if (key_sequence.len() < mtd_pkg::MaxSymbols) begin
          if (is_dash) begin
            key_sequence = {key_sequence, "-"};
          end else begin
            key_sequence = {key_sequence, "."};
          end
        end else begin
          key_overflow = 1'b1;
        end
        if (is_dash) begin
          push_symbol(mtd_pkg::KindDash, mtd_pkg::CharDash, 1'b1);
        end else begin
          push_symbol(mtd_pkg::KindDot, mtd_pkg::CharDot, 1'b1);
        end
      end
    end else if (span > thresholds[mtd_pkg::CfgGap]) begin
      // The key has been idle long enough: close the letter and always add a space.
      if (!key_overflow && key_sequence.len() != 0) begin
        for (int i = 0; i < 26; i++) begin
          if (morse_code[i] == key_sequence) begin
            letter = i;
          end
        end
      end
      if (letter >= 0) begin
        push_symbol(mtd_pkg::KindLetter, mtd_pkg::CharA + 7'(letter), 1'b0);
      end
      push_symbol(mtd_pkg::KindSpace, mtd_pkg::CharSpace, 1'b1);
      key_sequence = "";
      key_overflow = 1'b0;
      key_last_time = stamp;
    end
  endtask

  // Driver. An accepted item is decoded locally at the edge that takes it. The next
  // item is loaded only when the channel is free, so valid and the payload stay put
  // while the block stalls.
  always @(posedge clk or negedge rst_n) begin : key_driver
    key_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      key_last_time = '0;
      key_opening = 1'b1;
      key_sequence = "";
      key_overflow = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_key(op, ts);
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_keys.pop_front();
          in_valid <= 1'b1;
          op <= nxt.op;
          ts <= nxt.ts;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so that it runs on its own once requested.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result checker and receiver. Each accepted result is matched field by field with
  // the oldest expectation.
  always @(posedge clk or negedge rst_n) begin : result_check
    decoded_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch("unexpected result, kind", kind, 0);
        end else begin
          want = expected_symbols.pop_front();
          if (kind !== want.kind) begin
            report_mismatch("kind", kind, want.kind);
          end
          if (char_code !== want.code) begin
            report_mismatch("char_code", char_code, want.code);
          end
          if (last !== want.last) begin
            report_mismatch("last", last, want.last);
          end
        end
      end
      out_ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAIL morse_timing_decoder");
      $finish;
    end
  end

  // Queues one item. Edges always move the timeline; a poll only does so when it
  // exceeds the gap, just as in the block.
  task automatic push_item(logic item_op, logic [31:0] stamp);
    key_item_t it;
    logic [31:0] span;
    span = stamp - gen_time;
    it.op = item_op;
    it.ts = stamp;
    pending_keys.push_back(it);
    items_queued++;
    if (item_op == OpEdge || span > thresholds[mtd_pkg::CfgGap]) begin
      gen_time = stamp;
    end
  endtask

  // Keys one pattern of dots and dashes and then ends the letter with a poll. The
  // first edge of each symbol is assumed to open the key.
  task automatic key_letter(string pattern);
    logic [31:0] held;
    for (int i = 0; i < pattern.len(); i++) begin
      push_item(OpEdge, gen_time + $urandom_range(50, 1));
      if (pattern[i] == "-") begin
        held = $urandom_range(thresholds[mtd_pkg::CfgDashMax],
                              thresholds[mtd_pkg::CfgDotMax] + 1);
      end else begin
        held = $urandom_range(thresholds[mtd_pkg::CfgDotMax], thresholds[mtd_pkg::CfgDotMin]);
      end
      push_item(OpEdge, gen_time + held);
    end
    // Sometimes the key is polled before the gap has run out, which must do nothing.
    if ($urandom_range(3) == 0) begin
      push_item(OpPoll, gen_time + $urandom_range(thresholds[mtd_pkg::CfgGap], 0));
    end
    push_item(OpPoll, gen_time + thresholds[mtd_pkg::CfgGap] + 1 + $urandom_range(50, 0));
  endtask

  // Mostly well-formed letters with random timing, some long or empty sequences, and
  // some noise: random items, random stamps, and key presses outside both classes.
  task automatic random_keys(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    string       pattern;
    stop_at = items_queued + count;
    gen_time = $urandom();
    while (items_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        key_letter(morse_code[$urandom_range(25)]);
      end else if (pick < 80) begin
        pattern = "";
        for (int i = $urandom_range(6); i > 0; i--) begin
          if ($urandom_range(1) != 0) begin
            pattern = {pattern, "-"};
          end else begin
            pattern = {pattern, "."};
          end
        end
        key_letter(pattern);
      end else if (pick < 88) begin
        push_item(1'($urandom_range(1)), $urandom());
      end else if (pick < 94) begin
        push_item(1'($urandom_range(1)), gen_time + $urandom_range(3000));
      end else begin
        push_item(OpEdge, gen_time + $urandom_range(50, 1));
        push_item(OpEdge, gen_time + thresholds[mtd_pkg::CfgDashMax] + 1 + $urandom_range(9));
      end
    end
  endtask

  // Waits until the block has nothing left to do, then lets items that produce no
  // result settle.
  task automatic wait_quiet();
    while (pending_keys.size() != 0 || in_valid || expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(mtd_pkg::cfg_idx_e idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresholds[idx] = value;
  endtask

  task automatic set_thresholds(logic [31:0] dot_min, logic [31:0] dot_max,
                                logic [31:0] dash_max, logic [31:0] gap);
    wait_quiet();
    write_reg(mtd_pkg::CfgDotMin, dot_min);
    write_reg(mtd_pkg::CfgDotMax, dot_max);
    write_reg(mtd_pkg::CfgDashMax, dash_max);
    write_reg(mtd_pkg::CfgGap, gap);
  endtask

  task automatic random_thresholds();
    logic [31:0] dot_min;
    logic [31:0] dot_max;
    logic [31:0] dash_max;
    dot_min = $urandom_range(500, 1);
    dot_max = dot_min + $urandom_range(500);
    dash_max = dot_max + $urandom_range(1000, 1);
    set_thresholds(dot_min, dot_max, dash_max, dash_max + $urandom_range(1000));
  endtask

  initial begin
    thresholds[mtd_pkg::CfgDotMin] = mtd_pkg::DotMinReset;
    thresholds[mtd_pkg::CfgDotMax] = mtd_pkg::DotMaxReset;
    thresholds[mtd_pkg::CfgDashMax] = mtd_pkg::DashMaxReset;
    thresholds[mtd_pkg::CfgGap] = mtd_pkg::GapReset;
    send_idle_pct = 21;
    recv_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed keying at the reset thresholds. A poll right after reset sees no gap.
    push_item(OpPoll, 32'h0);
    // The first press straddles the timer wrap and lasts exactly the shortest dot.
    push_item(OpEdge, 32'hFFFF_FFFF);
    push_item(OpEdge, gen_time + 60000);
    // Longest dot, shortest dash and longest dash.
    push_item(OpEdge, gen_time + 1000);
    push_item(OpEdge, gen_time + 400000);
    push_item(OpEdge, gen_time + 1000);
    push_item(OpEdge, gen_time + 400001);
    push_item(OpEdge, gen_time + 5);
    push_item(OpEdge, gen_time + 800000);
    // Presses just too short and just too long give nothing.
    push_item(OpEdge, gen_time + 7);
    push_item(OpEdge, gen_time + 59999);
    push_item(OpEdge, gen_time + 7);
    push_item(OpEdge, gen_time + 800001);
    // A fifth symbol fills the sequence, and a sixth is reported but spoils it.
    push_item(OpEdge, gen_time + 9);
    push_item(OpEdge, gen_time + 200000);
    push_item(OpEdge, gen_time + 9);
    push_item(OpEdge, gen_time + 300000);
    // An idle time equal to the gap is not enough; one more tick gives only a space.
    push_item(OpPoll, gen_time + 800000);
    push_item(OpPoll, gen_time + 800001);
    // The letter M, then a poll over an empty sequence.
    key_letter("--");
    push_item(OpPoll, gen_time + 800001);

    // Extreme settings: every press is a dot and no poll ever ends the letter.
    set_thresholds(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_keys(30);
    // Only a zero length press is a dot, everything else a dash, and any idle tick
    // ends the letter.
    set_thresholds(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    random_keys(30);
    // The dash range is empty because it ends below the longest dot.
    set_thresholds(100, 1000, 500, 2000);
    random_keys(30);

    // Random thresholds under three idling patterns. In the last one the receiver is
    // held off for a long stretch while the input keeps offering items.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 21 : 0;
      for (int set = 0; set < 3; set++) begin
        random_thresholds();
        random_keys(75);
        if (phase == 2 && set == 0) begin
          @(posedge clk);
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (expected_symbols.size() != 0) begin
      report_mismatch("results never seen", expected_symbols.size(), 0);
    end
    if (mismatches == 0) begin
      $display("PASS morse_timing_decoder");
    end else begin
      $display("FAIL morse_timing_decoder");
    end
    $finish;
  end

endmodule
